### design/assert_macros.svh
// Assertion macros included by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bpfa_pkg.sv
// Types, codes and helper functions of the bitmap page frame allocator.
package bpfa_pkg;

  localparam int FRAME_W = 20;
  localparam int ADDR_W  = 29;
  localparam int COUNT_W = 18;
  localparam int WORD_W  = 32;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L2,
    ST_L1,
    ST_RMW,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FRAME_W-1:0] frame_number;
  } request_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  frame_address;
    logic               ok;
    logic [COUNT_W-1:0] free_count;
  } result_t;

  // Index of the lowest set bit of a word; zero when the word is empty.
  function automatic logic [4:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

### design/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator with its bitmap and summary memories.
//
// Commands enter on request (cmd, frame_number) and are accepted when start is high
// and busy is low. Every command gives exactly one item on result, shown for one cycle
// with done high; the receiver cannot stall it, so it must take the item then.
// Allocate returns the lowest free frame, scanned through a 32-way summary tree: a
// register of top flags, a summary memory with one bit per bitmap word (and one bit
// per summary word above it) and the bitmap memory itself.
// An allocate passes through the states L2, L1, RMW and UPD, free and reserve through
// RMW and UPD; out of memory, out-of-range frames and unused codes give done in the
// cycle after acceptance. busy falls in the cycle done is high, so the next command
// may be accepted then. Every memory read is registered: an allocate walks two summary
// levels and the bitmap in turn, then updates the summary path on the way back.
// After reset every frame is unavailable and the free count is zero; a clearing pass
// writes zero through both memories, with busy held high throughout.
module bitmap_page_frame_allocator #(
  parameter int BITMAP_WORDS = 4096,
  parameter int FRAME_SHIFT  = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bpfa_pkg::request_t  request,
  output logic                done,
  output bpfa_pkg::result_t   result
);

  `include "assert_macros.svh"

  localparam int W      = BITMAP_WORDS;
  localparam int WW     = (W > 1) ? $clog2(W) : 1;
  localparam int S      = (W + 31) / 32;
  localparam int T      = (S + 31) / 32;
  localparam int D      = S + T;
  localparam int DW     = $clog2(D);
  localparam int TW     = (T > 1) ? $clog2(T) : 1;
  localparam int CAP    = W * 32;
  localparam int CNTW   = $clog2(CAP + 1);
  localparam int CLR_N  = (W > D) ? W : D;
  localparam int CW     = $clog2(CLR_N);
  localparam int FULL_W = bpfa_pkg::FRAME_W + FRAME_SHIFT;

  bpfa_pkg::state_t state, state_next;

  logic [bpfa_pkg::WORD_W-1:0] bitmap_mem [W];
  logic [bpfa_pkg::WORD_W-1:0] summary_mem [D];

  logic                        bm_we, bm_re;
  logic [WW-1:0]               bm_waddr, bm_raddr;
  logic [bpfa_pkg::WORD_W-1:0] bm_wdata, bm_rdata;
  logic                        sum_we, sum_re;
  logic [DW-1:0]               sum_waddr, sum_raddr;
  logic [bpfa_pkg::WORD_W-1:0] sum_wdata, sum_rdata;

  logic [bpfa_pkg::FRAME_W-1:0] fr, fr_next;
  logic                         alloc_q, alloc_next;
  logic                         free_q, free_next;
  logic                         l1nz, l1nz_next;
  logic [T-1:0]                 top, top_next;
  logic [CNTW-1:0]              count, count_next;
  logic [CW-1:0]                clr, clr_next;
  logic                         done_next;
  bpfa_pkg::result_t            res_next;

  logic [4:0]                  top_lsb, i2, i1, bit_idx;
  logic                        was_free, in_range;
  logic [bpfa_pkg::WORD_W-1:0] new_bm, new_l1, new_l2;
  logic [FULL_W-1:0]           addr_full;
  logic [DW-1:0]               l2_addr;

  assign busy     = (state != bpfa_pkg::ST_IDLE);
  assign top_lsb  = bpfa_pkg::lowest_set(bpfa_pkg::WORD_W'(top));
  assign in_range = ({1'b0, request.frame_number} < (bpfa_pkg::FRAME_W + 1)'(CAP));
  assign l2_addr  = DW'(S) + DW'(fr[19:15]);
  assign addr_full = FULL_W'(fr) << FRAME_SHIFT;

  always_comb begin
    state_next = state;
    case (state)
      bpfa_pkg::ST_CLEAR: begin
        if (clr == CW'(CLR_N - 1)) begin
          state_next = bpfa_pkg::ST_IDLE;
        end
      end
      bpfa_pkg::ST_IDLE: begin
        if (start) begin
          case (request.cmd)
            bpfa_pkg::CMD_ALLOC: begin
              if (top != '0) begin
                state_next = bpfa_pkg::ST_L2;
              end
            end
            bpfa_pkg::CMD_FREE, bpfa_pkg::CMD_RESERVE: begin
              if (in_range) begin
                state_next = bpfa_pkg::ST_RMW;
              end
            end
            default: state_next = bpfa_pkg::ST_IDLE;
          endcase
        end
      end
      bpfa_pkg::ST_L2:  state_next = bpfa_pkg::ST_L1;
      bpfa_pkg::ST_L1:  state_next = bpfa_pkg::ST_RMW;
      bpfa_pkg::ST_RMW: state_next = bpfa_pkg::ST_UPD;
      bpfa_pkg::ST_UPD: state_next = bpfa_pkg::ST_IDLE;
      default:          state_next = bpfa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    bm_we      = 1'b0;
    bm_re      = 1'b0;
    bm_waddr   = WW'(fr[19:5]);
    bm_raddr   = WW'(fr[19:5]);
    bm_wdata   = '0;
    sum_we     = 1'b0;
    sum_re     = 1'b0;
    sum_waddr  = DW'(fr[19:10]);
    sum_raddr  = DW'(fr[19:10]);
    sum_wdata  = '0;
    fr_next    = fr;
    alloc_next = alloc_q;
    free_next  = free_q;
    l1nz_next  = l1nz;
    top_next   = top;
    count_next = count;
    clr_next   = clr;
    done_next  = 1'b0;
    res_next   = '0;
    res_next.free_count = bpfa_pkg::COUNT_W'(count);
    i2         = bpfa_pkg::lowest_set(sum_rdata);
    i1         = bpfa_pkg::lowest_set(sum_rdata);
    bit_idx    = alloc_q ? bpfa_pkg::lowest_set(bm_rdata) : fr[4:0];
    was_free   = bm_rdata[bit_idx];
    new_bm     = bm_rdata;
    new_l1     = sum_rdata;
    new_l2     = sum_rdata;
    case (state)
      bpfa_pkg::ST_CLEAR: begin
        bm_waddr  = WW'(clr);
        bm_we     = ({1'b0, clr} < (CW + 1)'(W));
        sum_waddr = DW'(clr);
        sum_we    = ({1'b0, clr} < (CW + 1)'(D));
        clr_next  = clr + CW'(1);
      end
      bpfa_pkg::ST_IDLE: begin
        if (start) begin
          fr_next    = request.frame_number;
          alloc_next = 1'b0;
          free_next  = (request.cmd == bpfa_pkg::CMD_FREE);
          case (request.cmd)
            bpfa_pkg::CMD_ALLOC: begin
              alloc_next = 1'b1;
              fr_next    = {top_lsb, 15'd0};
              if (top != '0) begin
                sum_re    = 1'b1;
                sum_raddr = DW'(S) + DW'(top_lsb);
              end else begin
                done_next = 1'b1;
              end
            end
            bpfa_pkg::CMD_FREE, bpfa_pkg::CMD_RESERVE: begin
              if (in_range) begin
                bm_re     = 1'b1;
                bm_raddr  = WW'(request.frame_number[19:5]);
                sum_re    = 1'b1;
                sum_raddr = DW'(request.frame_number[19:10]);
              end else begin
                done_next = 1'b1;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      bpfa_pkg::ST_L2: begin
        fr_next[14:10] = i2;
        sum_re         = 1'b1;
        sum_raddr      = DW'({fr[19:15], i2});
      end
      bpfa_pkg::ST_L1: begin
        fr_next[9:5] = i1;
        bm_re        = 1'b1;
        bm_raddr     = WW'({fr[19:10], i1});
      end
      bpfa_pkg::ST_RMW: begin
        fr_next[4:0]          = bit_idx;
        new_bm[bit_idx]       = free_q;
        bm_we                 = 1'b1;
        bm_wdata              = new_bm;
        new_l1[fr[9:5]]       = (new_bm != '0);
        sum_we                = 1'b1;
        sum_wdata             = new_l1;
        l1nz_next             = (new_l1 != '0);
        sum_re                = 1'b1;
        sum_raddr             = l2_addr;
        if (was_free != free_q) begin
          count_next = free_q ? (count + CNTW'(1)) : (count - CNTW'(1));
        end
      end
      bpfa_pkg::ST_UPD: begin
        new_l2[fr[14:10]]         = l1nz;
        sum_we                    = 1'b1;
        sum_waddr                 = l2_addr;
        sum_wdata                 = new_l2;
        top_next[TW'(fr[19:15])]  = (new_l2 != '0);
        done_next                 = 1'b1;
        res_next.ok               = 1'b1;
        res_next.frame_address    = alloc_q ? addr_full[bpfa_pkg::ADDR_W-1:0] : '0;
      end
      default: clr_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap_mem[bm_waddr] <= bm_wdata;
    end
    if (bm_re) begin
      bm_rdata <= bitmap_mem[bm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      summary_mem[sum_waddr] <= sum_wdata;
    end
    if (sum_re) begin
      sum_rdata <= summary_mem[sum_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpfa_pkg::ST_CLEAR;
      clr   <= '0;
      top   <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
      top   <= top_next;
      count <= count_next;
      done  <= done_next;
    end
    fr      <= fr_next;
    alloc_q <= alloc_next;
    free_q  <= free_next;
    l1nz    <= l1nz_next;
    result  <= res_next;
  end

  `ASSERT_IMPLIES(a_done_source, clk, rst, done,
    ($past(state) == bpfa_pkg::ST_UPD) || $past(start && !busy),
    "result strobe without a finished command")
  `ASSERT_IMPLIES(a_bm_port_clash, clk, rst, bm_we && bm_re, bm_waddr != bm_raddr,
    "bitmap read and write at the same entry")
  `ASSERT_IMPLIES(a_sum_port_clash, clk, rst, sum_we && sum_re, sum_waddr != sum_raddr,
    "summary read and write at the same entry")
  `ASSERT_NEXT(a_empty_alloc, clk, rst,
    start && !busy && (request.cmd == bpfa_pkg::CMD_ALLOC) && (top == '0),
    done && !result.ok, "allocate with no free frame must fail at once")

endmodule
